// ===== hdl/sblc_pkg.sv =====
// Package for the size-budget LRU cache: sizes, codes, payload and control types.
package sblc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;

  // Stored key width: the key field is 16 bits, narrowed further by KEY_BITS.
  localparam int KEY_W  = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = 3;

  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [31:0] CAPACITY_RESET = 32'd16777216;

  typedef enum logic [1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_LOADED   = 3'd1,
    ST_REJECTED = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_EVICTED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_MISS,
    S_EVCHK,
    S_CLRCHK,
    S_CLRFIN
  } state_t;

  // What the entry scan is looking for.
  typedef enum logic [1:0] {
    G_KEY,
    G_RANK,
    G_FREE
  } goal_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RECENT,
    OP_DROP,
    OP_INSERT,
    OP_CLEAR
  } table_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] object_key;
    logic [31:0] object_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_key;
    logic [31:0] used_total;
    logic [4:0]  entry_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    table_op_t        op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [31:0]      size;
  } table_cmd_t;

  typedef struct packed {
    logic [MAX_ENTRIES-1:0] valid_vec;
    logic                   valid;
    logic [KEY_W-1:0]       key;
    logic [31:0]            size;
    logic [IDX_W-1:0]       rank;
  } table_rd_t;

endpackage

// ===== hdl/sblc_table.sv =====
// Entry table: keys, sizes, valid bits and recency ranks, with one read port.
module sblc_table
  import sblc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  table_cmd_t cmd,
  output table_rd_t  rd
);

  logic [KEY_W-1:0]       keys  [MAX_ENTRIES];
  logic [31:0]            sizes [MAX_ENTRIES];
  logic [IDX_W-1:0]       ranks [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]       sel_rank;

  assign sel_rank     = ranks[cmd.idx];
  assign rd.valid_vec = valid;
  assign rd.valid     = valid[cmd.idx];
  assign rd.key       = keys[cmd.idx];
  assign rd.size      = sizes[cmd.idx];
  assign rd.rank      = sel_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_RECENT: begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid[i] && ranks[i] < sel_rank) begin
              ranks[i] <= ranks[i] + IDX_W'(1);
            end
          end
          ranks[cmd.idx] <= '0;
        end
        OP_DROP: begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid[i] && ranks[i] > sel_rank) begin
              ranks[i] <= ranks[i] - IDX_W'(1);
            end
          end
          valid[cmd.idx] <= 1'b0;
          ranks[cmd.idx] <= '0;
        end
        OP_INSERT: begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid[i]) begin
              ranks[i] <= ranks[i] + IDX_W'(1);
            end
          end
          valid[cmd.idx] <= 1'b1;
          ranks[cmd.idx] <= '0;
        end
        OP_CLEAR: begin
          valid <= '0;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ranks[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Key and size are payload and only written on insert.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_INSERT) begin
      keys[cmd.idx]  <= cmd.key;
      sizes[cmd.idx] <= cmd.size;
    end
  end

endmodule

// ===== hdl/size_budget_lru_cache_core.sv =====
// Top level of the size-budget LRU cache: sequencer, budget unit, output register, APB.
// A hit, remove or rejected load needs one key scan over the table entries.
// A miss that loads adds a rank scan per eviction and then a scan for a free slot.
// A clear runs a rank scan per resident entry, then finishes in S_CLRFIN.
// Throughput: one command at a time, in_ready high only while idle; output stalls delay it.
// Reset (synchronous, rst high) empties the table and sets the capacity to 16777216.
module size_budget_lru_cache_core
  import sblc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);

  // Sequencer registers and their next values.
  state_t           state, state_next;
  goal_t            goal, goal_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] target, target_next;
  logic [31:0]      used, used_next;
  logic [CNT_W-1:0] count, count_next;

  // The command being worked on, captured when its transaction is accepted.
  logic [1:0]       cmd;
  logic [KEY_W-1:0] key;
  logic [31:0]      size;

  logic [31:0] capacity;

  table_cmd_t tcmd;
  table_rd_t  trd;

  logic        out_free;
  logic        emit;
  status_t     emit_status;
  logic [15:0] emit_key;
  logic        emit_last;
  logic        match;
  logic [32:0] budget_sum;
  logic        over_budget;
  logic        table_full;

  sblc_table u_table (
    .clk (clk),
    .rst (rst),
    .cmd (tcmd),
    .rd  (trd)
  );

  // APB register file: a single capacity register, writes take effect at the access cycle.
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? capacity : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_CAPACITY) begin
      capacity <= pwdata;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // The shared comparator: each scan cycle checks the one entry under idx.
  always_comb begin
    case (goal)
      G_KEY:   match = trd.valid && (trd.key == key);
      G_RANK:  match = trd.valid && (trd.rank == target);
      G_FREE:  match = !trd.valid;
      default: match = 1'b0;
    endcase
  end

  // Budget check: used plus the new size must stay strictly below capacity.
  assign budget_sum  = {1'b0, used} + {1'b0, size};
  assign over_budget = (budget_sum >= {1'b0, capacity});
  assign table_full  = (count >= CNT_MAX);

  always_comb begin
    state_next  = state;
    goal_next   = goal;
    idx_next    = idx;
    target_next = target;
    used_next   = used;
    count_next  = count;
    emit        = 1'b0;
    emit_status = ST_HIT;
    emit_key    = 16'(key);
    emit_last   = 1'b0;
    tcmd.op     = OP_NONE;
    tcmd.idx    = idx;
    tcmd.key    = key;
    tcmd.size   = size;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.command)
            CMD_TOUCH, CMD_REMOVE: begin
              state_next = S_SCAN;
              goal_next  = G_KEY;
              idx_next   = '0;
            end
            CMD_CLEAR: begin
              state_next = S_CLRCHK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (match) begin
          state_next = S_ACT;
        end else if (idx == IDX_LAST) begin
          state_next = S_MISS;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end

      // Scan matched under idx; once the output is free, apply the change and report it.
      S_ACT: begin
        if (out_free) begin
          emit = 1'b1;
          case (goal)
            G_KEY: begin
              emit_last  = 1'b1;
              state_next = S_IDLE;
              if (cmd == CMD_TOUCH) begin
                tcmd.op     = OP_RECENT;
                emit_status = ST_HIT;
              end else begin
                tcmd.op     = OP_DROP;
                used_next   = used - trd.size;
                count_next  = count - CNT_W'(1);
                emit_status = ST_REMOVED;
              end
            end
            G_RANK: begin
              tcmd.op     = OP_DROP;
              used_next   = used - trd.size;
              count_next  = count - CNT_W'(1);
              emit_status = ST_EVICTED;
              emit_key    = 16'(trd.key);
              state_next  = (cmd == CMD_CLEAR) ? S_CLRCHK : S_EVCHK;
            end
            default: begin
              tcmd.op     = OP_INSERT;
              used_next   = used + size;
              count_next  = count + CNT_W'(1);
              emit_status = ST_LOADED;
              emit_last   = 1'b1;
              state_next  = S_IDLE;
            end
          endcase
        end
      end

      // The scan went through every entry without a match.
      S_MISS: begin
        case (goal)
          G_KEY: begin
            if (cmd == CMD_TOUCH) begin
              if (size >= capacity) begin
                if (out_free) begin
                  emit        = 1'b1;
                  emit_status = ST_REJECTED;
                  emit_last   = 1'b1;
                  state_next  = S_IDLE;
                end
              end else begin
                state_next = S_EVCHK;
              end
            end else if (out_free) begin
              emit        = 1'b1;
              emit_status = ST_ABSENT;
              emit_last   = 1'b1;
              state_next  = S_IDLE;
            end
          end
          G_RANK: begin
            if (cmd == CMD_CLEAR) begin
              state_next = S_CLRFIN;
            end else begin
              state_next = S_SCAN;
              goal_next  = G_FREE;
              idx_next   = '0;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // Evict the least recent entry while the new object does not fit or no slot is free.
      S_EVCHK: begin
        state_next = S_SCAN;
        idx_next   = '0;
        if (count != '0 && (over_budget || table_full)) begin
          goal_next   = G_RANK;
          target_next = IDX_W'(count - CNT_W'(1));
        end else begin
          goal_next = G_FREE;
        end
      end

      // Clear drops the most recent entry each round until the table is empty.
      S_CLRCHK: begin
        if (count != '0) begin
          state_next  = S_SCAN;
          goal_next   = G_RANK;
          target_next = '0;
          idx_next    = '0;
        end else begin
          state_next = S_CLRFIN;
        end
      end

      S_CLRFIN: begin
        if (out_free) begin
          emit        = 1'b1;
          tcmd.op     = OP_CLEAR;
          used_next   = '0;
          count_next  = '0;
          emit_status = ST_CLEARED;
          emit_key    = '0;
          emit_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      goal   <= G_KEY;
      idx    <= '0;
      target <= '0;
      used   <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      goal   <= goal_next;
      idx    <= idx_next;
      target <= target_next;
      used   <= used_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd  <= in_data.command;
      key  <= in_data.object_key[KEY_W-1:0];
      size <= in_data.object_size;
    end
  end

  // Output register: it holds one result so the sequencer can move on while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.status      <= emit_status;
      out_data.result_key  <= emit_key;
      out_data.used_total  <= used_next;
      out_data.entry_count <= 5'(count_next);
      out_data.last        <= emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("resident count exceeds the table size");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(trd.valid_vec) == count)
    else $error("resident count disagrees with the valid bits");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(emit && out_valid && !out_ready))
    else $error("result issued while the output register still holds one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.command != CMD_TOUCH &&
     in_data.command != CMD_REMOVE && in_data.command != CMD_CLEAR) |=> in_ready)
    else $error("unused command left the sequencer busy");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for size_budget_lru_cache_core: a shadow LRU table predicts every result stream.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sblc_pkg::*;

  // The unused command code is not part of command_t, so it gets a name here.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // A clear or a long eviction chain walks the whole table once per dropped entry,
  // so the settle wait covers any command still in flight with no result owed.
  localparam int SETTLE_CYCLES = MAX_ENTRIES * (MAX_ENTRIES + 2) + 4;

  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;

  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 20;
  localparam int KEY_POOL      = 24;

  // Shadow copy of the cache. Every accepted command is replayed here, and the
  // results it must cause are queued in order until the block reports them.
  class lru_tracker;
    bit [15:0]   slot_key  [MAX_ENTRIES];
    bit [31:0]   slot_size [MAX_ENTRIES];
    bit          slot_live [MAX_ENTRIES];
    int unsigned slot_age  [MAX_ENTRIES];
    longint unsigned used;
    int unsigned     count;
    bit [31:0]       capacity;
    out_item_t       pending_reports[$];
    int unsigned     mismatches;

    function new();
      capacity   = CAPACITY_RESET;
      used       = 0;
      count      = 0;
      mismatches = 0;
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
    endfunction

    function int locate_key(bit [15:0] key);
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_live[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int locate_age(int unsigned age);
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_live[i] && slot_age[i] == age) return i;
      return -1;
    endfunction

    function void promote(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void retire(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_live[i] && slot_age[i] > r) slot_age[i]--;
      slot_live[s] = 1'b0;
      slot_age[s]  = 0;
      used -= slot_size[s];
      if (count > 0) count--;
    endfunction

    function void report(status_t status, bit [15:0] key, bit last);
      out_item_t r;
      r.status      = status;
      r.result_key  = key;
      r.used_total  = used[31:0];
      r.entry_count = count[4:0];
      r.last        = last;
      pending_reports.push_back(r);
    endfunction

    function void note_command(in_item_t item);
      int s;
      int v;
      bit [15:0] vk;
      case (item.command)
        CMD_TOUCH: begin
          s = locate_key(item.object_key);
          if (s >= 0) begin
            promote(s);
            report(ST_HIT, item.object_key, 1'b1);
            return;
          end
          if (item.object_size >= capacity) begin
            report(ST_REJECTED, item.object_key, 1'b1);
            return;
          end
          // Sum in 64 bits: a large object on top of a large total must not wrap.
          while (count > 0 && (used + item.object_size >= capacity || count >= MAX_ENTRIES)) begin
            v = locate_age(count - 1);
            if (v < 0) break;
            vk = slot_key[v];
            retire(v);
            report(ST_EVICTED, vk, 1'b0);
          end
          s = -1;
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (!slot_live[i] && s < 0) s = i;
          if (s < 0) return;
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_live[i]) slot_age[i]++;
          slot_live[s] = 1'b1;
          slot_key[s]  = item.object_key;
          slot_size[s] = item.object_size;
          slot_age[s]  = 0;
          used += item.object_size;
          count++;
          report(ST_LOADED, item.object_key, 1'b1);
        end
        CMD_REMOVE: begin
          s = locate_key(item.object_key);
          if (s >= 0) begin
            retire(s);
            report(ST_REMOVED, item.object_key, 1'b1);
          end else begin
            report(ST_ABSENT, item.object_key, 1'b1);
          end
        end
        CMD_CLEAR: begin
          // Entries go out most recent first.
          while (count > 0) begin
            v = locate_age(0);
            if (v < 0) break;
            vk = slot_key[v];
            retire(v);
            report(ST_EVICTED, vk, 1'b0);
          end
          foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
          end
          used  = 0;
          count = 0;
          report(ST_CLEARED, 16'h0000, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected result: status %0d key %h used %0d count %0d last %0b",
               got.status, got.result_key, got.used_total, got.entry_count, got.last);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.result_key !== want.result_key) begin
        $error("result_key: expected %h, actual %h", want.result_key, got.result_key);
        mismatches++;
      end
      if (got.used_total !== want.used_total) begin
        $error("used_total: expected %0d, actual %0d", want.used_total, got.used_total);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Percentages of cycles in which the sender holds off and the receiver stalls.
  int gap_pct   = 0;
  int stall_pct = 0;

  lru_tracker tracker = new();
  bit [15:0]  key_pool[KEY_POOL];

  size_budget_lru_cache_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver side decides each cycle whether it can take a result.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels are sampled at the edge with their pre-edge values. A result is
  // checked before a new command is noted, because any result seen at that edge
  // belongs to an earlier command.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_report(out_data);
      if (in_valid && in_ready) tracker.note_command(in_data);
    end
  end

  // The watchdog ends the run once nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Presents one command and returns at the edge where it is accepted. Valid is
  // only lowered for an idle gap, so back-to-back transactions keep it high.
  task automatic send_command(input logic [1:0] cmd, input logic [15:0] key,
                              input logic [31:0] size);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, object_key: key, object_size: size};
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every predicted result has been seen, then lets
  // the block finish anything that owes no result, such as an unused command.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge that
  // ends the access cycle.
  task automatic write_capacity(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.capacity = value;
  endtask

  initial begin : stimulus
    logic [31:0] cap_plan[SEGMENTS];
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [31:0] size;
    logic [31:0] cap;
    int          issued;
    int          r;

    // A small key pool makes hits, removes of resident keys and reloads common,
    // while the two ends of the key range are always in it.
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    // Capacities per random segment: tight budgets, zero, the full range, and one
    // that only admits empty objects so the table fills by count alone.
    cap_plan[0] = 32'd1000;
    cap_plan[1] = 32'd0;
    cap_plan[2] = 32'hFFFF_FFFF;
    cap_plan[3] = $urandom_range(4096, 64);
    cap_plan[4] = 32'd1;
    cap_plan[5] = CAPACITY_RESET;
    cap_plan[6] = $urandom;
    cap_plan[7] = 32'd300;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run at the reset capacity with no idling.
    send_command(CMD_TOUCH, 16'h0000, 32'd0);
    // A hit ignores the size, even the largest one.
    send_command(CMD_TOUCH, 16'h0000, 32'hFFFF_FFFF);
    send_command(CMD_TOUCH, 16'hFFFF, CAPACITY_RESET - 1);
    // This load only fits after both residents are evicted, oldest first.
    send_command(CMD_TOUCH, 16'h0001, 32'd1);
    // A size equal to the capacity can never fit, nor can the largest size.
    send_command(CMD_TOUCH, 16'h0002, CAPACITY_RESET);
    send_command(CMD_TOUCH, 16'h0003, 32'hFFFF_FFFF);
    send_command(CMD_REMOVE, 16'h0001, 32'd0);
    send_command(CMD_REMOVE, 16'h0001, 32'd0);
    // Fill every slot with tiny objects, then one more load must evict by count.
    for (int k = 0; k < MAX_ENTRIES; k++) send_command(CMD_TOUCH, 16'h0010 + 16'(k), 32'd1);
    send_command(CMD_TOUCH, 16'h0020, 32'd1);
    // Clear drops all sixteen residents, most recent first.
    send_command(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_UNUSED, 16'h1234, 32'd5);

    // Random segments. Each starts from an idle block with a new capacity; the
    // idle pattern changes every two segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_for_quiet();
      write_capacity(cap_plan[seg]);
      case (seg / 2)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      cap    = cap_plan[seg];
      issued = 0;
      while (issued < SEGMENT_ITEMS) begin
        r = $urandom_range(99);
        if (r < 72)      cmd = CMD_TOUCH;
        else if (r < 92) cmd = CMD_REMOVE;
        else if (r < 96) cmd = CMD_CLEAR;
        else             cmd = CMD_UNUSED;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
        else                         key = $urandom;
        // Mostly objects up to a sixth of the budget, so both the size limit and
        // the entry limit drive evictions; a few empty, capacity-sized and huge ones.
        r = $urandom_range(99);
        if (r < 5)       size = 32'd0;
        else if (r < 10) size = cap;
        else if (r < 14) size = $urandom;
        else             size = $urandom_range(cap / 6);
        send_command(cmd, key, size);
        if (cmd != CMD_UNUSED) issued++;
      end
    end

    wait_for_quiet();
    if (tracker.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
